@@ design/kwm_pkg.sv @@
// Shared constants and controller/datapath interface types for the k-way merge.
package kwm_pkg;

   localparam int NUM_SOURCES = 8;
   localparam int KEY_WIDTH   = 32;
   localparam int SRC_W       = $clog2(NUM_SOURCES);

   localparam int FIELD_W     = 32;
   localparam int SRCIDX_W    = 3;
   localparam int CNT_W       = 16;
   localparam int TDATA_W     = 104;
   localparam logic [CNT_W-1:0] ROWS_PER_BLOCK_RST = 16'd256;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic             load;
      logic             scan_en;
      logic             scan_first;
      logic [SRC_W-1:0] scan_idx;
      logic             emit;
   } kwm_cmd_type;

   typedef struct packed {
      logic out_free;
   } kwm_stat_type;

endpackage

@@ design/kwm_ctrl.sv @@
// Controller state machine: request acceptance, head scan sequencing and emit.
module kwm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   input  kwm_pkg::kwm_stat_type stat,
   output kwm_pkg::kwm_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   localparam logic [kwm_pkg::SRC_W-1:0] LAST_IDX =
      kwm_pkg::SRC_W'(kwm_pkg::NUM_SOURCES - 1);

   state_type                  state_ff, state_in;
   logic [kwm_pkg::SRC_W-1:0]  idx_ff, idx_in;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      req_tready     = 1'b0;
      cmd.load       = 1'b0;
      cmd.scan_en    = 1'b0;
      cmd.scan_first = 1'b0;
      cmd.scan_idx   = idx_ff;
      cmd.emit       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == kwm_pkg::REQ_POP) begin
                  state_in = S_SCAN;
                  idx_in   = '0;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_en    = 1'b1;
            cmd.scan_first = (idx_ff == '0);
            if (idx_ff == LAST_IDX) begin
               state_in = S_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EMIT: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("emit issued while output register busy");

   a_first_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en && cmd.scan_first |-> cmd.scan_idx == '0)
      else $error("scan start not at source zero");

   a_scan_to_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en && cmd.scan_idx == LAST_IDX |=> !req_tready && !cmd.scan_en)
      else $error("scan end did not move to emit");
`endif

endmodule

@@ design/kwm_dp.sv @@
// Datapath: head store, sequential minimum scan, row counter and output register.
module kwm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  kwm_pkg::kwm_cmd_type          cmd,
   output kwm_pkg::kwm_stat_type         stat,
   input  logic                          csr_wr_en,
   input  logic [kwm_pkg::CNT_W-1:0]     csr_wr_data,
   input  logic [kwm_pkg::TDATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kwm_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int N  = kwm_pkg::NUM_SOURCES;
   localparam int KW = kwm_pkg::KEY_WIDTH;
   localparam int FW = kwm_pkg::FIELD_W;
   localparam int SW = kwm_pkg::SRC_W;

   // request fields
   logic [kwm_pkg::SRCIDX_W-1:0] req_src;
   logic [FW-1:0]                req_prim, req_sec, req_row;
   logic                         src_ok;
   logic [SW-1:0]                wr_idx;

   assign req_src  = req_tdata[2:0];
   assign req_prim = req_tdata[34:3];
   assign req_sec  = req_tdata[66:35];
   assign req_row  = req_tdata[98:67];
   assign src_ok   = (32'(req_src) < 32'(N));
   assign wr_idx   = SW'(req_src);

   // head store
   logic [N-1:0]  head_valid_ff, head_valid_in;
   logic [KW-1:0] head_prim_ff [N];
   logic [KW-1:0] head_prim_in [N];
   logic [KW-1:0] head_sec_ff  [N];
   logic [KW-1:0] head_sec_in  [N];
   logic [FW-1:0] head_row_ff  [N];
   logic [FW-1:0] head_row_in  [N];

   // scan state
   logic          found_ff, found_in;
   logic [SW-1:0] best_idx_ff, best_idx_in;
   logic [KW-1:0] best_prim_ff, best_prim_in;
   logic [KW-1:0] best_sec_ff, best_sec_in;
   logic [FW-1:0] best_row_ff, best_row_in;

   logic          found_eff, cand_less, take;

   // counter and config
   logic [kwm_pkg::CNT_W-1:0] rpb_ff, rpb_in;
   logic [kwm_pkg::CNT_W-1:0] cnt_ff, cnt_in, cnt_next;
   logic                      blk_hit;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kwm_pkg::TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic                        rsp_last_ff, rsp_last_in;

   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // scan compare: strictly smaller keeps the lowest index on ties
   assign found_eff = cmd.scan_first ? 1'b0 : found_ff;
   assign cand_less = {head_prim_ff[cmd.scan_idx], head_sec_ff[cmd.scan_idx]}
                      < {best_prim_ff, best_sec_ff};
   assign take      = cmd.scan_en && head_valid_ff[cmd.scan_idx] &&
                      (!found_eff || cand_less);

   assign cnt_next = cnt_ff + 1'b1;
   assign blk_hit  = (cnt_next == rpb_ff);

   always_comb begin
      head_valid_in = head_valid_ff;
      head_prim_in  = head_prim_ff;
      head_sec_in   = head_sec_ff;
      head_row_in   = head_row_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_prim_in  = best_prim_ff;
      best_sec_in   = best_sec_ff;
      best_row_in   = best_row_ff;
      rpb_in        = rpb_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         rpb_in = csr_wr_data;
      end

      if (cmd.load && src_ok) begin
         head_valid_in[wr_idx] = 1'b1;
         head_prim_in[wr_idx]  = KW'(req_prim);
         head_sec_in[wr_idx]   = KW'(req_sec);
         head_row_in[wr_idx]   = req_row;
      end

      if (cmd.scan_en) begin
         found_in = found_eff;
      end
      if (take) begin
         found_in     = 1'b1;
         best_idx_in  = cmd.scan_idx;
         best_prim_in = head_prim_ff[cmd.scan_idx];
         best_sec_in  = head_sec_ff[cmd.scan_idx];
         best_row_in  = head_row_ff[cmd.scan_idx];
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            head_valid_in[best_idx_ff] = 1'b0;
            rsp_empty_in = 1'b0;
            rsp_last_in  = blk_hit;
            rsp_data_in  = {5'd0, best_row_ff, FW'(best_sec_ff), FW'(best_prim_ff),
                            kwm_pkg::SRCIDX_W'(best_idx_ff)};
            cnt_in       = blk_hit ? '0 : cnt_next;
         end else begin
            rsp_empty_in = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_data_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         found_ff      <= 1'b0;
         rpb_ff        <= kwm_pkg::ROWS_PER_BLOCK_RST;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         found_ff      <= found_in;
         rpb_ff        <= rpb_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_prim_ff <= head_prim_in;
      head_sec_ff  <= head_sec_in;
      head_row_ff  <= head_row_in;
      best_idx_ff  <= best_idx_in;
      best_prim_ff <= best_prim_in;
      best_sec_ff  <= best_sec_in;
      best_row_ff  <= best_row_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_emit_frees_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && found_ff |=> !head_valid_ff[$past(best_idx_ff)])
      else $error("emitted head still valid");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_data_ff == '0 && !rsp_last_ff)
      else $error("empty result carries data");

   a_block_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && found_ff && blk_hit |=> cnt_ff == '0)
      else $error("row counter not cleared at block end");

   a_empty_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !found_ff |=> $stable(cnt_ff))
      else $error("row counter moved on empty pop");
`endif

endmodule

@@ design/kway_merge_two_key_top.sv @@
// Top level of the two-key k-way merge: controller and datapath.
//
// Usage:
//   req_* carries requests. req_tuser = 0 loads the head of source
//   req_tdata[2:0] with its primary key, secondary key and row handle;
//   a load gives no response. req_tuser = 1 pops the smallest valid head
//   (primary key, then secondary key, lowest source on ties).
//   rsp_* returns one response per pop: rsp_tuser flags an empty store
//   (data and tlast zero), rsp_tlast marks the row that completes a block
//   of rows_per_block rows, written through csr_wr_en / csr_wr_data.
// Timing:
//   A pop scans the heads one source per cycle, then waits until the output
//   register is free and writes the response into it; no request is accepted
//   while a pop is in progress.
// Reset clears all head valid bits, the row counter, and sets
// rows_per_block to 256. A stalled response sits in the output register;
// the block keeps taking requests, and a following pop waits at its end
// until the output register is free.
module kway_merge_two_key_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [kwm_pkg::CNT_W-1:0]   csr_wr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // source[2:0], key_primary[34:3], key_secondary[66:35], row_handle[98:67]
   input  logic [kwm_pkg::TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_source[2:0], out_primary[34:3], out_secondary[66:35], out_row[98:67]
   output logic [kwm_pkg::TDATA_W-1:0] rsp_tdata,
   // store_empty[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   kwm_pkg::kwm_cmd_type  cmd;
   kwm_pkg::kwm_stat_type stat;

   kwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kwm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
